@@ rtl/ddmn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddmn_pkg: shared widths, codes and types of the differential-drive mixer
// Field widths, register indexes, reset values, status codes and the
// request/response bundles of the serial divider.
// ----------------------------------------------------------------------------
package ddmn_pkg;

   localparam int TIME_W     = 63;
   localparam int CMD_W      = 16;
   localparam int SPEED_W    = 15;
   localparam int IWB_W      = 16;
   localparam int AGE_W      = 32;
   localparam int LIN_W      = 16;
   localparam int ANG_W      = 24;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // divider geometry: numerator, divisor, long and short quotient lengths
   localparam int NUM_W      = 64;
   localparam int DEN_W      = 39;
   localparam int QUOT_W     = 25;
   localparam int QUOT_SHORT = 16;
   localparam int CNT_W      = 5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OLD   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_WHEEL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_AGE     = 2'd2;

   localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 15'd1229;
   localparam logic [IWB_W-1:0]   INV_WHEEL_RST   = 16'd1280;
   localparam logic [AGE_W-1:0]   MAX_AGE_RST     = 32'd200000000;

   typedef struct packed {
      logic             start;
      logic             wide;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/ddmn_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddmn_req_if: command channel
// Valid/ready channel carrying one timestamped joystick command per word.
// ----------------------------------------------------------------------------
interface ddmn_req_if;
   logic                                valid;
   logic                                ready;
   logic [ddmn_pkg::TIME_W-1:0]         stamp;
   logic [ddmn_pkg::TIME_W-1:0]         current_time;
   logic signed [ddmn_pkg::CMD_W-1:0]   linear_cmd;
   logic signed [ddmn_pkg::CMD_W-1:0]   turn_cmd;

   modport source (output valid, stamp, current_time, linear_cmd, turn_cmd, input ready);
   modport sink   (input valid, stamp, current_time, linear_cmd, turn_cmd, output ready);
endinterface
`default_nettype wire

@@ rtl/ddmn_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddmn_rsp_if: result channel
// Valid/ready channel carrying status, linear speed and turn rate per word.
// ----------------------------------------------------------------------------
interface ddmn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ddmn_pkg::STATUS_W-1:0]       status;
   logic signed [ddmn_pkg::LIN_W-1:0]   linear_out;
   logic signed [ddmn_pkg::ANG_W-1:0]   angular_out;

   modport source (output valid, status, linear_out, angular_out, input ready);
   modport sink   (input valid, status, linear_out, angular_out, output ready);
endinterface
`default_nettype wire

@@ rtl/ddmn_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ddmn_div: bit-serial restoring divider
// One quotient bit per cycle; the caller guarantees the quotient fits the
// selected length (16 or 25 bits), so the partial remainder starts from the
// numerator's upper bits and stays below the divisor.
// ----------------------------------------------------------------------------
module ddmn_div (
   input  wire                        clock,
   input  wire                        reset,
   input  wire ddmn_pkg::div_cmd_type cmd,
   output ddmn_pkg::div_rsp_type      rsp
);

   logic [ddmn_pkg::DEN_W-1:0]  rem_ff;
   logic [ddmn_pkg::DEN_W-1:0]  den_ff;
   logic [ddmn_pkg::QUOT_W-1:0] numlo_ff;
   logic [ddmn_pkg::QUOT_W-1:0] quot_ff;
   logic [ddmn_pkg::CNT_W-1:0]  cnt_ff;
   logic                        busy_ff;
   logic                        done_ff;

   logic [ddmn_pkg::DEN_W:0]    trial;
   logic [ddmn_pkg::DEN_W:0]    diff;
   logic                        fits;

   assign trial = {rem_ff, numlo_ff[ddmn_pkg::QUOT_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            den_ff  <= cmd.den;
            quot_ff <= '0;
            if (cmd.wide) begin
               rem_ff   <= cmd.num[ddmn_pkg::QUOT_W +: ddmn_pkg::DEN_W];
               numlo_ff <= cmd.num[ddmn_pkg::QUOT_W-1:0];
               cnt_ff   <= ddmn_pkg::CNT_W'(ddmn_pkg::QUOT_W);
            end else begin
               rem_ff   <= cmd.num[ddmn_pkg::QUOT_SHORT +: ddmn_pkg::DEN_W];
               numlo_ff <= {cmd.num[ddmn_pkg::QUOT_SHORT-1:0],
                            (ddmn_pkg::QUOT_W - ddmn_pkg::QUOT_SHORT)'(0)};
               cnt_ff   <= ddmn_pkg::CNT_W'(ddmn_pkg::QUOT_SHORT);
            end
         end else if (busy_ff) begin
            rem_ff   <= fits ? diff[ddmn_pkg::DEN_W-1:0] : trial[ddmn_pkg::DEN_W-1:0];
            quot_ff  <= {quot_ff[ddmn_pkg::QUOT_W-2:0], fits};
            numlo_ff <= {numlo_ff[ddmn_pkg::QUOT_W-2:0], 1'b0};
            cnt_ff   <= cnt_ff - 1'b1;
            if (cnt_ff == ddmn_pkg::CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule
`default_nettype wire

@@ rtl/diff_drive_mix_normalize_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_mix_normalize_unit: joystick to wheel-speed mixer
// Age and ordering checks, wheel mixing with desaturation, speed/turn output.
// ----------------------------------------------------------------------------
// One command word is taken at a time and yields exactly one result word. A
// command older than max_age gives status 1, a stamp not newer than the last
// accepted one gives status 2; both leave the state alone and return zero
// speeds. An accepted command within the limit gives its result without
// the divider; one that needs desaturation runs through the shared
// bit-serial divider (one quotient bit per cycle: 16 bits for linear
// speed, then 25 bits for turn rate). One shared multiplier serves every
// multiplying step. The next command is taken the cycle after the result
// is loaded. A finished result sits in an output register, so the next
// command is taken while it waits; a second result holds until that
// register is free. Configuration writes are taken in any cycle; write
// them only while no command is in flight.
// ----------------------------------------------------------------------------
module diff_drive_mix_normalize_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   ddmn_req_if.sink                             req_ch,
   ddmn_rsp_if.source                           rsp_ch,
   input  wire                                  csr_we,
   input  wire [ddmn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [ddmn_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_AGE, S_CHK, S_MPL, S_MPT, S_MIX, S_MAX, S_CMP,
      S_MLN, S_MA1, S_MA2, S_RND, S_DIVS, S_DIVW, S_NLN, S_NAN, S_FIN
   } state_type;

   state_type                         state_ff;

   logic [ddmn_pkg::SPEED_W-1:0]      speed_limit_ff;
   logic [ddmn_pkg::IWB_W-1:0]        inv_wheel_ff;
   logic [ddmn_pkg::AGE_W-1:0]        max_age_ff;

   logic [ddmn_pkg::TIME_W-1:0]       st_ff;
   logic [ddmn_pkg::TIME_W-1:0]       cur_ff;
   logic [ddmn_pkg::CMD_W-1:0]        lin_ff;
   logic [ddmn_pkg::CMD_W-1:0]        trn_ff;
   logic [ddmn_pkg::TIME_W-1:0]       age_ff;
   logic                              later_ff;
   logic [ddmn_pkg::TIME_W-1:0]       last_ff;
   logic                              stamp_valid_ff;

   logic [29:0]                       plmag_ff;
   logic [29:0]                       ptmag_ff;
   logic signed [31:0]                vl_ff;
   logic signed [31:0]                vr_ff;
   logic [30:0]                       m_ff;
   logic [ddmn_pkg::NUM_W-1:0]        num_ff;
   logic [ddmn_pkg::DEN_W-1:0]        den_ff;
   logic                              wide_ff;
   logic [ddmn_pkg::QUOT_W-1:0]       lmag_ff;
   logic [ddmn_pkg::QUOT_W-1:0]       amag_ff;
   logic [ddmn_pkg::STATUS_W-1:0]     status_ff;

   logic                              rsp_valid_ff;
   logic [ddmn_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [ddmn_pkg::LIN_W-1:0]        rsp_lin_ff;
   logic [ddmn_pkg::ANG_W-1:0]        rsp_ang_ff;
   logic                              rsp_load;

   logic [44:0]                       mul_a;
   logic [15:0]                       mul_b;
   logic [60:0]                       mul_out;
   logic [ddmn_pkg::TIME_W:0]         age_diff;
   logic [15:0]                       lin_mag;
   logic [15:0]                       trn_mag;
   logic signed [31:0]                pl_s;
   logic signed [31:0]                pt_s;
   logic [31:0]                       vl_abs;
   logic [31:0]                       vr_abs;
   logic [ddmn_pkg::LIN_W-1:0]        lin_sat;
   logic [ddmn_pkg::ANG_W-1:0]        ang_sat;
   logic [47:0]                       ang_round;

   ddmn_pkg::div_cmd_type             div_cmd;
   ddmn_pkg::div_rsp_type             div_rsp;

   // -------------------------------------------------------------------------
   // Datapath helpers
   // -------------------------------------------------------------------------
   assign age_diff = {1'b0, cur_ff} - {1'b0, st_ff};
   assign lin_mag  = lin_ff[ddmn_pkg::CMD_W-1] ? (~lin_ff + 1'b1) : lin_ff;
   assign trn_mag  = trn_ff[ddmn_pkg::CMD_W-1] ? (~trn_ff + 1'b1) : trn_ff;
   assign pl_s     = lin_ff[ddmn_pkg::CMD_W-1] ? -$signed({2'b00, plmag_ff})
                                               :  $signed({2'b00, plmag_ff});
   assign pt_s     = trn_ff[ddmn_pkg::CMD_W-1] ? -$signed({2'b00, ptmag_ff})
                                               :  $signed({2'b00, ptmag_ff});
   assign vl_abs   = vl_ff[31] ? 32'(-vl_ff) : 32'(vl_ff);
   assign vr_abs   = vr_ff[31] ? 32'(-vr_ff) : 32'(vr_ff);
   assign ang_round = {1'b0, num_ff[45:0], 1'b0} + 48'(1 << 22);

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MPL: begin
            mul_a = 45'(lin_mag);
            mul_b = 16'(speed_limit_ff);
         end
         S_MPT: begin
            mul_a = 45'(trn_mag);
            mul_b = 16'(speed_limit_ff);
         end
         S_MLN: begin
            mul_a = 45'(plmag_ff);
            mul_b = 16'(speed_limit_ff);
         end
         S_MA1: begin
            mul_a = 45'(ptmag_ff);
            mul_b = 16'(speed_limit_ff);
         end
         S_MA2: begin
            mul_a = num_ff[44:0];
            mul_b = inv_wheel_ff;
         end
         S_NLN: begin
            mul_a = 45'(ptmag_ff);
            mul_b = inv_wheel_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_out = mul_a * mul_b;

   // saturate to field ranges
   always_comb begin
      if (lin_ff[ddmn_pkg::CMD_W-1]) begin
         lin_sat = (lmag_ff > ddmn_pkg::QUOT_W'(32768)) ? 16'h8000 : 16'(~lmag_ff + 1'b1);
      end else begin
         lin_sat = (lmag_ff > ddmn_pkg::QUOT_W'(32767)) ? 16'h7FFF : lmag_ff[15:0];
      end
      if (trn_ff[ddmn_pkg::CMD_W-1]) begin
         ang_sat = (amag_ff > ddmn_pkg::QUOT_W'(8388608)) ? 24'h800000
                                                         : 24'(~amag_ff + 1'b1);
      end else begin
         ang_sat = (amag_ff > ddmn_pkg::QUOT_W'(8388607)) ? 24'h7FFFFF : amag_ff[23:0];
      end
   end

   assign div_cmd.start = (state_ff == S_DIVS);
   assign div_cmd.wide  = wide_ff;
   assign div_cmd.num   = num_ff;
   assign div_cmd.den   = den_ff;

   ddmn_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // load the output register once it is free or being drained this cycle
   assign rsp_load = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= ddmn_pkg::SPEED_LIMIT_RST;
         inv_wheel_ff   <= ddmn_pkg::INV_WHEEL_RST;
         max_age_ff     <= ddmn_pkg::MAX_AGE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            ddmn_pkg::CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata[ddmn_pkg::SPEED_W-1:0];
            ddmn_pkg::CSR_INV_WHEEL:   inv_wheel_ff   <= csr_wdata[ddmn_pkg::IWB_W-1:0];
            ddmn_pkg::CSR_MAX_AGE:     max_age_ff     <= csr_wdata[ddmn_pkg::AGE_W-1:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         stamp_valid_ff <= 1'b0;
         last_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  st_ff    <= req_ch.stamp;
                  cur_ff   <= req_ch.current_time;
                  lin_ff   <= req_ch.linear_cmd;
                  trn_ff   <= req_ch.turn_cmd;
                  state_ff <= S_AGE;
               end
            end
            S_AGE: begin
               age_ff   <= age_diff[ddmn_pkg::TIME_W-1:0];
               later_ff <= !age_diff[ddmn_pkg::TIME_W] &&
                           (age_diff[ddmn_pkg::TIME_W-1:0] != '0);
               state_ff <= S_CHK;
            end
            S_CHK: begin
               lmag_ff <= '0;
               amag_ff <= '0;
               if (later_ff && (age_ff > ddmn_pkg::TIME_W'(max_age_ff))) begin
                  status_ff <= ddmn_pkg::STATUS_OLD;
                  state_ff  <= S_FIN;
               end else if (stamp_valid_ff && (st_ff <= last_ff)) begin
                  status_ff <= ddmn_pkg::STATUS_ORDER;
                  state_ff  <= S_FIN;
               end else begin
                  status_ff      <= ddmn_pkg::STATUS_OK;
                  last_ff        <= st_ff;
                  stamp_valid_ff <= 1'b1;
                  state_ff       <= S_MPL;
               end
            end
            S_MPL: begin
               plmag_ff <= mul_out[29:0];
               state_ff <= S_MPT;
            end
            S_MPT: begin
               ptmag_ff <= mul_out[29:0];
               state_ff <= S_MIX;
            end
            S_MIX: begin
               vl_ff    <= pl_s - pt_s;
               vr_ff    <= pl_s + pt_s;
               state_ff <= S_MAX;
            end
            S_MAX: begin
               m_ff     <= (vl_abs > vr_abs) ? vl_abs[30:0] : vr_abs[30:0];
               state_ff <= S_CMP;
            end
            S_CMP: begin
               // desaturate only when the faster wheel passes the limit
               if (m_ff > {1'b0, speed_limit_ff, 15'd0}) begin
                  state_ff <= S_MLN;
               end else begin
                  state_ff <= S_NLN;
               end
            end
            S_MLN: begin
               num_ff   <= ddmn_pkg::NUM_W'(mul_out);
               den_ff   <= ddmn_pkg::DEN_W'(m_ff);
               wide_ff  <= 1'b0;
               state_ff <= S_RND;
            end
            S_MA1: begin
               num_ff   <= ddmn_pkg::NUM_W'(mul_out);
               state_ff <= S_MA2;
            end
            S_MA2: begin
               num_ff   <= {2'b00, mul_out, 1'b0};
               den_ff   <= {m_ff, 8'd0};
               wide_ff  <= 1'b1;
               state_ff <= S_RND;
            end
            S_RND: begin
               // bias by half the divisor for round-half-away
               num_ff   <= num_ff + ddmn_pkg::NUM_W'(den_ff >> 1);
               state_ff <= S_DIVS;
            end
            S_DIVS: begin
               state_ff <= S_DIVW;
            end
            S_DIVW: begin
               if (div_rsp.done) begin
                  if (wide_ff) begin
                     amag_ff  <= div_rsp.quot;
                     state_ff <= S_FIN;
                  end else begin
                     lmag_ff  <= div_rsp.quot;
                     state_ff <= S_MA1;
                  end
               end
            end
            S_NLN: begin
               lmag_ff  <= ddmn_pkg::QUOT_W'(({1'b0, plmag_ff} + 31'(1 << 14)) >> 15);
               num_ff   <= ddmn_pkg::NUM_W'(mul_out);
               state_ff <= S_NAN;
            end
            S_NAN: begin
               amag_ff  <= ang_round[47:23];
               state_ff <= S_FIN;
            end
            S_FIN: begin
               // hold until the output register is free
               if (rsp_load) begin
                  rsp_status_ff <= status_ff;
                  rsp_lin_ff    <= lin_sat;
                  rsp_ang_ff    <= ang_sat;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.linear_out  = rsp_lin_ff;
   assign rsp_ch.angular_out = rsp_ang_ff;

endmodule
`default_nettype wire
